FILE: rtl/core/mtcs_pkg.sv
`timescale 1ns / 1ps
package mtcs_pkg;
    typedef enum logic [2:0] {
        MODE_DISCONNECTED = 3'd0,
        MODE_IDLE         = 3'd1,
        MODE_RECEIVING    = 3'd3,
        MODE_RUNNING      = 3'd4,
        MODE_PAUSED       = 3'd5
    } mode_t;

    localparam logic [3:0] CMD_PING   = 4'd0;
    localparam logic [3:0] CMD_HOME   = 4'd1;
    localparam logic [3:0] CMD_MANUAL = 4'd2;
    localparam logic [3:0] CMD_BEGIN  = 4'd3;
    localparam logic [3:0] CMD_POINT  = 4'd4;
    localparam logic [3:0] CMD_END    = 4'd5;
    localparam logic [3:0] CMD_RUN    = 4'd6;
    localparam logic [3:0] CMD_PAUSE  = 4'd7;
    localparam logic [3:0] CMD_RESUME = 4'd8;
    localparam logic [3:0] CMD_ABORT  = 4'd9;
    localparam logic [3:0] CMD_GETPOS = 4'd10;
    localparam logic [3:0] CMD_TICK   = 4'd11;

    localparam logic [3:0] K_PONG      = 4'd0;
    localparam logic [3:0] K_READY     = 4'd1;
    localparam logic [3:0] K_OK        = 4'd2;
    localparam logic [3:0] K_POSITION  = 4'd3;
    localparam logic [3:0] K_TRAJREADY = 4'd4;
    localparam logic [3:0] K_ACK       = 4'd5;
    localparam logic [3:0] K_STORED    = 4'd6;
    localparam logic [3:0] K_RUNNING   = 4'd7;
    localparam logic [3:0] K_PROGRESS  = 4'd8;
    localparam logic [3:0] K_FINISHED  = 4'd9;
    localparam logic [3:0] K_PAUSED    = 4'd10;
    localparam logic [3:0] K_ABORTED   = 4'd11;
    localparam logic [3:0] K_ERROR     = 4'd12;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_STATE    = 3'd1;
    localparam logic [2:0] E_AXIS     = 3'd2;
    localparam logic [2:0] E_COUNT    = 3'd3;
    localparam logic [2:0] E_MISMATCH = 3'd4;
    localparam logic [2:0] E_UNKNOWN  = 3'd5;

    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_BAD   = 2'd3;

    localparam logic [1:0] REG_X_LIMIT     = 2'd0;
    localparam logic [1:0] REG_Y_LIMIT     = 2'd1;
    localparam logic [1:0] REG_ANGLE_LOWER = 2'd2;
    localparam logic [1:0] REG_ANGLE_UPPER = 2'd3;

    // last member sits in the lowest bits, matching the s_tdata layout
    typedef struct packed {
        logic [31:0] delta_angle;
        logic [31:0] delta_y;
        logic [31:0] delta_x;
        logic [31:0] dt_ms;
        logic [15:0] point_count;
        logic [31:0] jog_steps;
        logic        direction;
        logic [1:0]  axis;
        logic [3:0]  command;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  error_code;
        logic [11:0] point_index;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_angle;
        logic [31:0] angle_upper;
        logic [31:0] elapsed_ms;
        logic        last;
    } result_t;
endpackage

FILE: rtl/core/motion_trajectory_command_sequencer.sv
`timescale 1ns / 1ps
// Three-axis motion command sequencer. Each s_ transfer carries one decoded command and
// yields one result on m_ (none for a tick while not running, two for the tick that plays
// the final point: progress, then finished with tlast). An accepted command goes through two
// steps: the first registers the command and issues the point store read, the second forms
// the results in the output register; no new command is taken until that pass is through
// and the output queue is draining. The store holds POINT_DEPTH absolute points and is read
// only after being written; there is no clearing pass after reset.
module motion_trajectory_command_sequencer #(
    parameter int POINT_DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[3:0], axis[5:4], direction[6], jog_steps[38:7], point_count[54:39],
    // dt_ms[86:55], delta_x[118:87], delta_y[150:119], delta_angle[182:151], zero fill
    input  logic [183:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[3:0], error_code[6:4], point_index[18:7], pos_x[50:19], pos_y[82:51],
    // pos_angle[114:83], angle_upper[146:115], elapsed_ms[178:147], zero fill
    output logic [183:0] m_tdata,
    output logic        m_tlast
);
    import mtcs_pkg::*;

    localparam int AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
    localparam int CW = $clog2(POINT_DEPTH + 1);

    logic [30:0] x_limit_reg, y_limit_reg;
    logic [31:0] angle_lower_reg, angle_upper_reg;

    mode_t       mode_reg, mode_next;
    logic [31:0] cur_x_reg, cur_y_reg, cur_a_reg;
    logic [31:0] cur_x_next, cur_y_next, cur_a_next;
    logic [31:0] acc_x_reg, acc_y_reg, acc_a_reg;
    logic [31:0] acc_x_next, acc_y_next, acc_a_next;
    logic [CW-1:0] exp_reg, exp_next, recv_reg, recv_next, play_reg, play_next;
    logic        stored_reg, stored_next;
    logic [31:0] elapsed_reg, elapsed_next;

    cmd_t        cmd_reg;
    logic        busy_reg;
    result_t     res0_next, res1_next;
    logic        two_next;
    logic        wr_en;

    // output queue of up to two results
    result_t     q0_reg, q1_reg;
    logic [1:0]  qcnt_reg;

    logic [31:0] rd_t, rd_x, rd_y, rd_a;

    assign s_tready = !busy_reg && (qcnt_reg == 2'd0 || (qcnt_reg == 2'd1 && m_tready));
    assign m_tvalid = qcnt_reg != 2'd0;
    assign m_tdata  = {5'd0, q0_reg.elapsed_ms, q0_reg.angle_upper, q0_reg.pos_angle,
                       q0_reg.pos_y, q0_reg.pos_x, q0_reg.point_index, q0_reg.error_code,
                       q0_reg.kind};
    assign m_tlast  = q0_reg.last;

    mtcs_ram #(.WIDTH(32), .DEPTH(POINT_DEPTH)) u_time (
        .aclk, .wr_en, .wr_addr(recv_reg[AW-1:0]), .wr_data(cmd_reg.dt_ms),
        .rd_addr(play_reg[AW-1:0]), .rd_data(rd_t));
    mtcs_ram #(.WIDTH(32), .DEPTH(POINT_DEPTH)) u_x (
        .aclk, .wr_en, .wr_addr(recv_reg[AW-1:0]), .wr_data(acc_x_next),
        .rd_addr(play_reg[AW-1:0]), .rd_data(rd_x));
    mtcs_ram #(.WIDTH(32), .DEPTH(POINT_DEPTH)) u_y (
        .aclk, .wr_en, .wr_addr(recv_reg[AW-1:0]), .wr_data(acc_y_next),
        .rd_addr(play_reg[AW-1:0]), .rd_data(rd_y));
    mtcs_ram #(.WIDTH(32), .DEPTH(POINT_DEPTH)) u_a (
        .aclk, .wr_en, .wr_addr(recv_reg[AW-1:0]), .wr_data(acc_a_next),
        .rd_addr(play_reg[AW-1:0]), .rd_data(rd_a));

    always_comb begin
        result_t     simple;
        logic [31:0] d;
        mode_next    = mode_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        cur_a_next   = cur_a_reg;
        acc_x_next   = acc_x_reg + cmd_reg.delta_x;
        acc_y_next   = acc_y_reg + cmd_reg.delta_y;
        acc_a_next   = acc_a_reg + cmd_reg.delta_angle;
        exp_next     = exp_reg;
        recv_next    = recv_reg;
        play_next    = play_reg;
        stored_next  = stored_reg;
        elapsed_next = elapsed_reg;
        wr_en        = 1'b0;
        two_next     = 1'b0;
        simple       = '0;
        simple.last  = 1'b1;
        res0_next    = simple;
        res1_next    = simple;
        res1_next.kind = K_FINISHED;
        d = cmd_reg.direction ? cmd_reg.jog_steps : 32'd0 - cmd_reg.jog_steps;
        case (cmd_reg.command)
            CMD_PING: res0_next.kind = K_PONG;
            CMD_HOME: begin
                cur_x_next = '0;
                cur_y_next = '0;
                cur_a_next = '0;
                mode_next  = MODE_IDLE;
                res0_next.kind        = K_READY;
                res0_next.pos_x       = {1'b0, x_limit_reg};
                res0_next.pos_y       = {1'b0, y_limit_reg};
                res0_next.pos_angle   = angle_lower_reg;
                res0_next.angle_upper = angle_upper_reg;
            end
            CMD_MANUAL: begin
                if (mode_reg != MODE_IDLE) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else if (cmd_reg.axis == AXIS_BAD) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_AXIS;
                end else begin
                    res0_next.kind = K_OK;
                    if (cmd_reg.axis == AXIS_X) cur_x_next = cur_x_reg + d;
                    else if (cmd_reg.axis == AXIS_Y) cur_y_next = cur_y_reg + d;
                    else cur_a_next = cur_a_reg + d;
                end
            end
            CMD_BEGIN: begin
                if (mode_reg != MODE_IDLE) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else if (cmd_reg.point_count == 16'd0 ||
                             32'(cmd_reg.point_count) > 32'(POINT_DEPTH)) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_COUNT;
                end else begin
                    exp_next    = CW'(cmd_reg.point_count);
                    recv_next   = '0;
                    stored_next = 1'b0;
                    acc_x_next  = cur_x_reg;
                    acc_y_next  = cur_y_reg;
                    acc_a_next  = cur_a_reg;
                    mode_next   = MODE_RECEIVING;
                    res0_next.kind = K_TRAJREADY;
                end
            end
            CMD_POINT: begin
                if (mode_reg != MODE_RECEIVING) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else if (recv_reg >= exp_reg) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_MISMATCH;
                end else begin
                    wr_en     = 1'b1;
                    recv_next = recv_reg + 1'b1;
                    res0_next.kind        = K_ACK;
                    res0_next.point_index = 12'(recv_reg);
                end
            end
            CMD_END: begin
                if (mode_reg != MODE_RECEIVING) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else begin
                    mode_next = MODE_IDLE;
                    if (recv_reg != exp_reg) begin
                        res0_next.kind = K_ERROR; res0_next.error_code = E_MISMATCH;
                    end else begin
                        stored_next = 1'b1;
                        res0_next.kind = K_STORED;
                    end
                end
            end
            CMD_RUN: begin
                if (mode_reg != MODE_IDLE || !stored_reg) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else begin
                    mode_next    = MODE_RUNNING;
                    play_next    = '0;
                    elapsed_next = '0;
                    res0_next.kind = K_RUNNING;
                end
            end
            CMD_PAUSE: begin
                if (mode_reg != MODE_RUNNING) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else begin
                    mode_next = MODE_PAUSED; res0_next.kind = K_PAUSED;
                end
            end
            CMD_RESUME: begin
                if (mode_reg != MODE_PAUSED) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else begin
                    mode_next = MODE_RUNNING; res0_next.kind = K_RUNNING;
                end
            end
            CMD_ABORT: begin
                if (mode_reg != MODE_PAUSED) begin
                    res0_next.kind = K_ERROR; res0_next.error_code = E_STATE;
                end else begin
                    mode_next = MODE_IDLE; res0_next.kind = K_ABORTED;
                end
            end
            CMD_GETPOS: begin
                res0_next.kind      = K_POSITION;
                res0_next.pos_x     = cur_x_reg;
                res0_next.pos_y     = cur_y_reg;
                res0_next.pos_angle = cur_a_reg;
            end
            CMD_TICK: begin
                if (play_reg >= recv_reg) begin
                    mode_next = MODE_IDLE;
                    res0_next.kind = K_FINISHED;
                end else begin
                    cur_x_next   = rd_x;
                    cur_y_next   = rd_y;
                    cur_a_next   = rd_a;
                    elapsed_next = elapsed_reg + rd_t;
                    play_next    = play_reg + 1'b1;
                    res0_next.kind       = K_PROGRESS;
                    res0_next.pos_x      = rd_x;
                    res0_next.pos_y      = rd_y;
                    res0_next.pos_angle  = rd_a;
                    res0_next.elapsed_ms = elapsed_next;
                    if (play_next >= recv_reg) begin
                        mode_next      = MODE_IDLE;
                        res0_next.last = 1'b0;
                        two_next       = 1'b1;
                    end
                end
            end
            default: begin
                res0_next.kind = K_ERROR; res0_next.error_code = E_UNKNOWN;
            end
        endcase
        if (cmd_reg.command != CMD_POINT && cmd_reg.command != CMD_BEGIN) begin
            acc_x_next = acc_x_reg;
            acc_y_next = acc_y_reg;
            acc_a_next = acc_a_reg;
        end
    end

    // a tick while not running produces nothing and changes nothing
    logic silent;
    assign silent = cmd_reg.command == CMD_TICK && mode_reg != MODE_RUNNING;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg     <= 31'd48000;
            y_limit_reg     <= 31'd72000;
            angle_lower_reg <= -32'sd5000;
            angle_upper_reg <= 32'd5400;
            mode_reg    <= MODE_DISCONNECTED;
            cur_x_reg   <= '0; cur_y_reg <= '0; cur_a_reg <= '0;
            acc_x_reg   <= '0; acc_y_reg <= '0; acc_a_reg <= '0;
            exp_reg     <= '0; recv_reg <= '0; play_reg <= '0;
            stored_reg  <= 1'b0;
            elapsed_reg <= '0;
            busy_reg    <= 1'b0;
            qcnt_reg    <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_X_LIMIT:     x_limit_reg     <= cfg_data[30:0];
                    REG_Y_LIMIT:     y_limit_reg     <= cfg_data[30:0];
                    REG_ANGLE_LOWER: angle_lower_reg <= cfg_data;
                    REG_ANGLE_UPPER: angle_upper_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                q0_reg   <= q1_reg;
                qcnt_reg <= qcnt_reg - 2'd1;
            end
            if (s_tvalid && s_tready) begin
                cmd_reg  <= s_tdata[182:0];
                busy_reg <= 1'b1;
            end
            if (busy_reg) begin
                busy_reg <= 1'b0;
                if (!silent) begin
                    mode_reg    <= mode_next;
                    cur_x_reg   <= cur_x_next; cur_y_reg <= cur_y_next;
                    cur_a_reg   <= cur_a_next;
                    acc_x_reg   <= acc_x_next; acc_y_reg <= acc_y_next;
                    acc_a_reg   <= acc_a_next;
                    exp_reg     <= exp_next; recv_reg <= recv_next;
                    play_reg    <= play_next;
                    stored_reg  <= stored_next;
                    elapsed_reg <= elapsed_next;
                    // queue is empty here: s_tready required it to drain
                    q0_reg   <= res0_next;
                    q1_reg   <= res1_next;
                    qcnt_reg <= two_next ? 2'd2 : 2'd1;
                end
            end
        end
    end
endmodule

FILE: rtl/core/mtcs_ram.sv
`timescale 1ns / 1ps
module mtcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/core/mtcs_checker.sv
`timescale 1ns / 1ps
module mtcs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic         m_tlast
);
    import mtcs_pkg::*;

    // commands never overlap: the cycle after a transfer is never ready
    a_no_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted two cycles running");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped while stalled");

    // only a progress result can be followed by another from the same command
    a_nonlast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> m_tdata[3:0] == K_PROGRESS)
        else $error("non-final result is not progress");

    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] != K_ERROR) |-> m_tdata[6:4] == E_NONE)
        else $error("error code on a non-error result");
endmodule

bind motion_trajectory_command_sequencer mtcs_checker u_mtcs_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import mtcs_pkg::*;

    localparam int DEPTH = 512;
    localparam int STALL_LIMIT = 20000;

    // one expected result kept by the sequencer model
    typedef struct {
        logic [3:0]  kind;
        logic [2:0]  error_code;
        logic [11:0] point_index;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_angle;
        logic [31:0] angle_upper;
        logic [31:0] elapsed_ms;
        logic        last;
    } resp_t;

    class sequencer_scoreboard;
        logic [30:0] x_lim, y_lim;
        logic [31:0] a_lo, a_hi;
        mode_t       mode;
        logic [31:0] cur_x, cur_y, cur_a, acc_x, acc_y, acc_a, elapsed;
        int          n_expected, n_received, play_idx;
        bit          stored;
        logic [31:0] pt_time [DEPTH];
        logic [31:0] pt_x [DEPTH];
        logic [31:0] pt_y [DEPTH];
        logic [31:0] pt_a [DEPTH];
        resp_t       pending[$];
        int          mismatches;

        function new();
            x_lim = 31'd48000;
            y_lim = 31'd72000;
            a_lo = -32'sd5000;
            a_hi = 32'sd5400;
            mode = MODE_DISCONNECTED;
            {cur_x, cur_y, cur_a, acc_x, acc_y, acc_a, elapsed} = '0;
            n_expected = 0;
            n_received = 0;
            play_idx = 0;
            stored = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_X_LIMIT: x_lim = val[30:0];
                REG_Y_LIMIT: y_lim = val[30:0];
                REG_ANGLE_LOWER: a_lo = val;
                default: a_hi = val;
            endcase
        endfunction

        function void push(logic [3:0] k, logic [2:0] e, logic [11:0] idx, logic [31:0] px,
                           logic [31:0] py, logic [31:0] pa, logic [31:0] au,
                           logic [31:0] el, logic lst);
            resp_t r;
            r.kind = k; r.error_code = e; r.point_index = idx; r.pos_x = px; r.pos_y = py;
            r.pos_angle = pa; r.angle_upper = au; r.elapsed_ms = el; r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_command(cmd_t c);
            logic [31:0] d;
            int i;
            case (c.command)
                CMD_PING: push(K_PONG, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                CMD_HOME: begin
                    {cur_x, cur_y, cur_a} = '0;
                    mode = MODE_IDLE;
                    push(K_READY, E_NONE, 0, {1'b0, x_lim}, {1'b0, y_lim}, a_lo, a_hi, 0, 1);
                end
                CMD_MANUAL: begin
                    if (mode != MODE_IDLE) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else if (c.axis == AXIS_BAD) push(K_ERROR, E_AXIS, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        d = c.direction ? c.jog_steps : -c.jog_steps;
                        if (c.axis == AXIS_X) cur_x += d;
                        else if (c.axis == AXIS_Y) cur_y += d;
                        else cur_a += d;
                        push(K_OK, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_BEGIN: begin
                    if (mode != MODE_IDLE) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else if (c.point_count == 0 || c.point_count > DEPTH)
                        push(K_ERROR, E_COUNT, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        n_expected = c.point_count;
                        n_received = 0;
                        stored = 0;
                        acc_x = cur_x; acc_y = cur_y; acc_a = cur_a;
                        mode = MODE_RECEIVING;
                        push(K_TRAJREADY, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_POINT: begin
                    if (mode != MODE_RECEIVING) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else if (n_received >= n_expected)
                        push(K_ERROR, E_MISMATCH, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        acc_x += c.delta_x; acc_y += c.delta_y; acc_a += c.delta_angle;
                        i = n_received;
                        pt_time[i] = c.dt_ms; pt_x[i] = acc_x;
                        pt_y[i] = acc_y; pt_a[i] = acc_a;
                        n_received++;
                        push(K_ACK, E_NONE, i[11:0], 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_END: begin
                    if (mode != MODE_RECEIVING) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        mode = MODE_IDLE;
                        if (n_received != n_expected)
                            push(K_ERROR, E_MISMATCH, 0, 0, 0, 0, 0, 0, 1);
                        else begin
                            stored = 1;
                            push(K_STORED, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                        end
                    end
                end
                CMD_RUN: begin
                    if (mode != MODE_IDLE || !stored) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        mode = MODE_RUNNING; play_idx = 0; elapsed = 0;
                        push(K_RUNNING, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_PAUSE: begin
                    if (mode != MODE_RUNNING) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        mode = MODE_PAUSED;
                        push(K_PAUSED, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_RESUME: begin
                    if (mode != MODE_PAUSED) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        mode = MODE_RUNNING;
                        push(K_RUNNING, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_ABORT: begin
                    if (mode != MODE_PAUSED) push(K_ERROR, E_STATE, 0, 0, 0, 0, 0, 0, 1);
                    else begin
                        mode = MODE_IDLE;
                        push(K_ABORTED, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                CMD_GETPOS: push(K_POSITION, E_NONE, 0, cur_x, cur_y, cur_a, 0, 0, 1);
                CMD_TICK: begin
                    if (mode == MODE_RUNNING) begin
                        if (play_idx >= n_received) begin
                            mode = MODE_IDLE;
                            push(K_FINISHED, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                        end else begin
                            i = play_idx;
                            cur_x = pt_x[i]; cur_y = pt_y[i]; cur_a = pt_a[i];
                            elapsed += pt_time[i];
                            play_idx++;
                            if (play_idx >= n_received) begin
                                mode = MODE_IDLE;
                                push(K_PROGRESS, E_NONE, 0, cur_x, cur_y, cur_a, 0, elapsed, 0);
                                push(K_FINISHED, E_NONE, 0, 0, 0, 0, 0, 0, 1);
                            end else
                                push(K_PROGRESS, E_NONE, 0, cur_x, cur_y, cur_a, 0, elapsed, 1);
                        end
                    end
                end
                default: push(K_ERROR, E_UNKNOWN, 0, 0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_result(result_t got, logic got_last);
            resp_t e;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result kind %0d", got.kind);
                return;
            end
            e = pending.pop_front();
            bad = got.kind !== e.kind || got.error_code !== e.error_code
                || got.point_index !== e.point_index || got.pos_x !== e.pos_x
                || got.pos_y !== e.pos_y || got.pos_angle !== e.pos_angle
                || got.angle_upper !== e.angle_upper || got.elapsed_ms !== e.elapsed_ms
                || got_last !== e.last;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch exp k%0d e%0d i%0d x%h y%h a%h u%h t%h l%0d",
                              " got k%0d e%0d i%0d x%h y%h a%h u%h t%h l%0d"},
                             e.kind, e.error_code, e.point_index, e.pos_x, e.pos_y,
                             e.pos_angle, e.angle_upper, e.elapsed_ms, e.last,
                             got.kind, got.error_code, got.point_index, got.pos_x, got.pos_y,
                             got.pos_angle, got.angle_upper, got.elapsed_ms, got_last);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [183:0] m_tdata;
    logic         m_tlast;

    sequencer_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;
    int  long_hold;

    always #6 aclk = ~aclk;

    motion_trajectory_command_sequencer #(.POINT_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // pack and unpack the fields listed on the port comments
    function automatic logic [183:0] pack_cmd(cmd_t c);
        return {1'b0, c.delta_angle, c.delta_y, c.delta_x, c.dt_ms, c.point_count,
                c.jog_steps, c.direction, c.axis, c.command};
    endfunction

    function automatic result_t unpack_result(logic [183:0] d);
        result_t r;
        r.kind = d[3:0]; r.error_code = d[6:4]; r.point_index = d[18:7];
        r.pos_x = d[50:19]; r.pos_y = d[82:51]; r.pos_angle = d[114:83];
        r.angle_upper = d[146:115]; r.elapsed_ms = d[178:147]; r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_t rand_cmd(logic [3:0] op);
        cmd_t c;
        c.command = op;
        c.axis = 2'($urandom_range(0, 3));
        c.direction = 1'($urandom_range(0, 1));
        c.jog_steps = rand_word();
        c.point_count = 16'($urandom);
        c.dt_ms = rand_word();
        c.delta_x = rand_word();
        c.delta_y = rand_word();
        c.delta_angle = rand_word();
        return c;
    endfunction

    // watchdog and result side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(unpack_result(m_tdata), m_tlast);
    end

    initial begin : receiver
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold > 0) begin
                m_tready <= 0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stim_done) gap = 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    int  burst_fast;

    // s_tvalid stays high after a transfer until the next send or drain replaces it
    task automatic send(cmd_t c);
        int gap;
        gap = (burst_fast > 0) ? 0 : $urandom_range(0, 17);
        if (burst_fast > 0) burst_fast--;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= pack_cmd(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(c);
    endtask

    task automatic send_op(logic [3:0] op);
        send(rand_cmd(op));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // a whole trajectory: begin, points, end, run and ticks, with random disruptions when not clean
    task automatic trajectory(int n, bit clean);
        cmd_t c;
        c = rand_cmd(CMD_BEGIN);
        c.point_count = 16'(n);
        send(c);
        for (int i = 0; i < n + (clean ? 0 : $urandom_range(0, 2)); i++) begin
            if (!clean && $urandom_range(0, 19) == 0) send_op(4'($urandom_range(0, 15)));
            c = rand_cmd(CMD_POINT);
            if ($urandom_range(0, 1)) begin
                c.delta_x = $signed($urandom_range(0, 200)) - 100;
                c.dt_ms = $urandom_range(0, 300);
            end
            send(c);
            if (!clean && $urandom_range(0, 30) == 0) break;
        end
        send_op(CMD_END);
        send_op(CMD_RUN);
        for (int i = 0; i < n + 1; i++) begin
            if (!clean && $urandom_range(0, 9) == 0)
                send_op($urandom_range(0, 1) ? CMD_PAUSE :
                        ($urandom_range(0, 1) ? CMD_RESUME : CMD_ABORT));
            send_op(CMD_TICK);
        end
        if ($urandom_range(0, 1)) send_op(CMD_GETPOS);
    endtask

    initial begin : stimulus
        cmd_t c;
        int   n;
        sb = new();
        idle_cycles = 0;
        stim_done = 0;
        long_hold = 0;
        burst_fast = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: ping, manual, tick, run and an unknown command before homing, then the special cases
        send_op(CMD_PING);
        send_op(CMD_MANUAL);
        send_op(CMD_TICK);
        send_op(CMD_RUN);
        send_op(4'd15);
        send_op(CMD_HOME);
        c = rand_cmd(CMD_MANUAL); c.axis = AXIS_BAD; send(c);
        c = rand_cmd(CMD_MANUAL); c.axis = AXIS_X; c.direction = 0;
        c.jog_steps = 32'h8000_0000; send(c);
        c = rand_cmd(CMD_BEGIN); c.point_count = 0; send(c);
        c = rand_cmd(CMD_BEGIN); c.point_count = 16'hffff; send(c);
        c = rand_cmd(CMD_BEGIN); c.point_count = 2; send(c);
        send_op(CMD_POINT);
        send_op(CMD_POINT);
        send_op(CMD_POINT);
        send_op(CMD_END);
        send_op(CMD_RUN);
        send_op(CMD_RESUME);
        send_op(CMD_PAUSE);
        send_op(CMD_ABORT);
        send_op(CMD_RUN);
        send_op(CMD_TICK);
        send_op(CMD_TICK);
        send_op(CMD_TICK);
        send_op(CMD_GETPOS);
        send_op(4'd12);
        drain();

        write_reg(REG_X_LIMIT, 32'h7fff_ffff);
        write_reg(REG_Y_LIMIT, 32'h0);
        write_reg(REG_ANGLE_LOWER, 32'h8000_0000);
        write_reg(REG_ANGLE_UPPER, 32'h7fff_ffff);
        send_op(CMD_HOME);

        // full-depth trajectory stored and started once, with the receiver holding off meanwhile
        c = rand_cmd(CMD_BEGIN); c.point_count = 16'(DEPTH); send(c);
        long_hold = 300;
        burst_fast = 40;
        for (int i = 0; i < DEPTH; i++) begin
            c = rand_cmd(CMD_POINT); send(c);
        end
        send_op(CMD_END);
        send_op(CMD_RUN);
        send_op(CMD_TICK);
        send_op(CMD_HOME);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_X_LIMIT, $urandom);
            write_reg(REG_Y_LIMIT, ph == 3 ? 32'h0 : $urandom);
            write_reg(REG_ANGLE_LOWER, rand_word());
            write_reg(REG_ANGLE_UPPER, rand_word());
            send_op(CMD_HOME);
            for (int t = 0; t < 29; t++) begin
                if ($urandom_range(0, 3) == 0) burst_fast = $urandom_range(0, 30);
                case ($urandom_range(0, 9))
                    0, 1: for (int k = 0; k < 4; k++) send_op(4'($urandom_range(0, 15)));
                    2: send_op(CMD_MANUAL);
                    3: send_op(CMD_HOME);
                    default: begin
                        n = $urandom_range(1, 6);
                        trajectory(n, $urandom_range(0, 2) != 0);
                    end
                endcase
            end
            drain();
        end
        stim_done = 1;
        drain();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
